// ===== src/pairwise_euclidean_distance_assert.svh =====
// Assertion macros for the pairwise Euclidean distance block.
// Included by the top level; needs clk and arst_n in scope.
`ifndef PAIRWISE_EUCLIDEAN_DISTANCE_ASSERT_SVH
`define PAIRWISE_EUCLIDEAN_DISTANCE_ASSERT_SVH

// Implication checked on every clock while out of reset.
`define PED_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PED_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== src/ped_pkg.sv =====
// Package for the pairwise Euclidean distance block: sizes and payload types.
// No dependencies.
package ped_pkg;
	localparam int MaxDescriptors = 64;
	localparam int MaxDim = 64;
	localparam int ValueBits = 16;
	localparam int DimCountBits = 7;
	localparam int DimCountReset = 64;
	localparam int DistBits = 20;

	typedef struct packed {
		logic [15:0] descriptor_id;
		logic signed [ValueBits-1:0] element_value;
		logic end_of_descriptor;
		logic start_of_set;
	} in_item_t;

	typedef struct packed {
		logic [15:0] earlier_id;
		logic [15:0] later_id;
		logic [19:0] distance;
		logic status;
		logic last_result;
	} out_item_t;
endpackage

// ===== src/ped_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ped_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/pairwise_euclidean_distance.sv =====
// Top level of the pairwise Euclidean distance block.
// Uses ped_pkg, ped_ram and pairwise_euclidean_distance_assert.svh.
//
// Channel   Handshake                 Payload
// input     start / busy              item  (ped_pkg::in_item_t)
// result    result_valid (strobe)     result (ped_pkg::out_item_t)
// config    dim_count_we              dim_count_wdata
//
// A plain element is taken while busy is low and leaves busy low. The last
// element of a descriptor first zero-fills the rest of its slot, then for every
// earlier descriptor reads the vector RAM, squares and accumulates the
// differences, loads the square root, runs it at one bit per cycle and emits
// one result. A descriptor that finds the store full is dropped with a status
// result. busy stays high until the last result has left. Reset clears the
// state and counts and reloads the dim count. Results cannot be stalled.
module pairwise_euclidean_distance #(
	parameter int MAX_DESCRIPTORS = ped_pkg::MaxDescriptors,
	parameter int MAX_DIM = ped_pkg::MaxDim
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  ped_pkg::in_item_t item,
	output logic result_valid,
	output ped_pkg::out_item_t result,
	input  logic dim_count_we,
	input  logic [ped_pkg::DimCountBits-1:0] dim_count_wdata
);
	localparam int VALUE_BITS = ped_pkg::ValueBits;
	localparam int SlotBits = $clog2(MAX_DESCRIPTORS);
	localparam int ElemBits = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
	localparam int AddrBits = $clog2(MAX_DESCRIPTORS * MAX_DIM);
	localparam int CntBits = $clog2(MAX_DESCRIPTORS + 1);
	localparam int IdxBits = $clog2(MAX_DIM + 1);
	localparam int DiffBits = VALUE_BITS + 1;
	localparam int SqBits = 2 * DiffBits;
	localparam int SumBits0 = SqBits + $clog2(MAX_DIM + 1);
	localparam int SumBits = SumBits0 + (SumBits0 % 2);
	localparam int RootBits = SumBits / 2;
	localparam int RootCntBits = $clog2(RootBits + 1);
	localparam int DistBits = ped_pkg::DistBits;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FILL, ST_READ, ST_ACC, ST_ROOT, ST_EMIT
	} state_t;

	state_t state_q;
	logic [ped_pkg::DimCountBits-1:0] dim_count_q;
	logic [CntBits-1:0] stored_count_q;
	logic [IdxBits-1:0] element_index_q;
	logic [IdxBits-1:0] fill_q;
	logic [SlotBits-1:0] pair_q;
	logic [IdxBits-1:0] rd_idx_q;
	logic [15:0] later_id_q;
	logic [SumBits-1:0] sum_q, rem_q;
	// The partial root is scaled by the current bit weight, so it needs the full sum width.
	logic [SumBits-1:0] root_q;
	logic [RootCntBits-1:0] root_cnt_q;
	logic read_s1, read_s2;
	logic signed [SqBits-1:0] sq_s2;
	logic signed [VALUE_BITS-1:0] cur_s1;
	logic [1:0] cur_phase_q;

	logic [IdxBits-1:0] dim_eff;
	always_comb begin
		if (dim_count_q == '0) begin
			dim_eff = IdxBits'(1);
		end else if (32'(dim_count_q) > MAX_DIM) begin
			dim_eff = IdxBits'(MAX_DIM);
		end else begin
			dim_eff = IdxBits'(dim_count_q);
		end
	end

	// Vector RAM: one write port for loading and fill, one read port.
	logic vec_we;
	logic [AddrBits-1:0] vec_waddr, vec_raddr;
	logic [VALUE_BITS-1:0] vec_wdata, vec_rdata;
	logic id_we;
	logic [SlotBits-1:0] id_waddr;
	logic [15:0] id_rdata;

	ped_ram #(.Width(VALUE_BITS), .Depth(MAX_DESCRIPTORS * MAX_DIM)) u_vec_ram (
		.clk(clk), .we(vec_we), .waddr(vec_waddr), .wdata(vec_wdata),
		.raddr(vec_raddr), .rdata(vec_rdata)
	);
	ped_ram #(.Width(16), .Depth(MAX_DESCRIPTORS)) u_id_ram (
		.clk(clk), .we(id_we), .waddr(id_waddr), .wdata(item.descriptor_id),
		.raddr(pair_q), .rdata(id_rdata)
	);

	logic accept;
	assign accept = start && !busy;
	assign busy = state_q != ST_IDLE;

	// Counts as seen by the accepted item after an optional start of set.
	logic [CntBits-1:0] cnt_eff;
	logic [IdxBits-1:0] idx_eff;
	logic full;
	logic [SlotBits-1:0] new_slot;
	assign cnt_eff = item.start_of_set ? '0 : stored_count_q;
	assign idx_eff = item.start_of_set ? '0 : element_index_q;
	assign full = 32'(cnt_eff) >= MAX_DESCRIPTORS;
	assign new_slot = SlotBits'(stored_count_q);

	// The read address alternates between the earlier slot and the new slot.
	logic [SlotBits-1:0] rd_slot;
	assign rd_slot = cur_phase_q[0] ? new_slot : pair_q;

	always_comb begin
		vec_we = 1'b0;
		vec_waddr = '0;
		vec_wdata = item.element_value[VALUE_BITS-1:0];
		id_we = 1'b0;
		id_waddr = SlotBits'(cnt_eff);
		if (state_q == ST_IDLE) begin
			vec_waddr = AddrBits'(32'(SlotBits'(cnt_eff)) * MAX_DIM)
				+ AddrBits'(ElemBits'(idx_eff));
			vec_we = accept && !full && idx_eff < dim_eff;
			id_we = accept && !full && item.end_of_descriptor;
		end else if (state_q == ST_FILL) begin
			vec_waddr = AddrBits'(32'(new_slot) * MAX_DIM) + AddrBits'(ElemBits'(fill_q));
			vec_wdata = '0;
			vec_we = fill_q < IdxBits'(MAX_DIM);
		end
		vec_raddr = AddrBits'(32'(rd_slot) * MAX_DIM) + AddrBits'(ElemBits'(rd_idx_q));
	end

	// One square-root step: classic digit-by-digit, one result bit per cycle.
	logic [SumBits-1:0] trial;
	logic [SumBits-1:0] bitv;
	assign bitv = SumBits'(1) << (2 * (RootBits - 32'(root_cnt_q)));
	assign trial = root_q + bitv;

	logic signed [DiffBits-1:0] diff;
	assign diff = DiffBits'(cur_s1) - DiffBits'($signed(vec_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_count_q <= ped_pkg::DimCountBits'(ped_pkg::DimCountReset);
			stored_count_q <= '0;
			element_index_q <= '0;
			result_valid <= 1'b0;
			read_s1 <= 1'b0;
			read_s2 <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (dim_count_we) begin
				dim_count_q <= dim_count_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stored_count_q <= cnt_eff;
						element_index_q <= (idx_eff < dim_eff) ? idx_eff + 1'b1 : idx_eff;
						later_id_q <= item.descriptor_id;
						if (item.end_of_descriptor) begin
							element_index_q <= '0;
							if (full) begin
								result_valid <= 1'b1;
								result <= '{earlier_id: '0, later_id: item.descriptor_id,
									distance: '0, status: 1'b1, last_result: 1'b1};
							end else begin
								fill_q <= (idx_eff < dim_eff) ? idx_eff + 1'b1 : idx_eff;
								state_q <= ST_FILL;
							end
						end
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q >= IdxBits'(MAX_DIM - 1)) begin
						if (stored_count_q == '0) begin
							stored_count_q <= stored_count_q + 1'b1;
							state_q <= ST_IDLE;
						end else begin
							pair_q <= '0;
							rd_idx_q <= '0;
							cur_phase_q <= 2'd1;
							sum_q <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// Phase 1 reads the new slot, phase 0 the earlier one, then square.
					read_s1 <= 1'b0;
					read_s2 <= read_s1;
					if (read_s1) begin
						sq_s2 <= diff * diff;
					end
					if (read_s2) begin
						sum_q <= sum_q + SumBits'($unsigned(sq_s2));
					end
					if (cur_phase_q == 2'd1) begin
						cur_phase_q <= 2'd0;
					end else if (cur_phase_q == 2'd0) begin
						cur_phase_q <= 2'd2;
						cur_s1 <= $signed(vec_rdata);
					end else if (cur_phase_q == 2'd2) begin
						read_s1 <= 1'b1;
						if (rd_idx_q == dim_eff - 1'b1) begin
							cur_phase_q <= 2'd3;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							cur_phase_q <= 2'd1;
						end
					end else begin
						if (!read_s1 && !read_s2) begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					rem_q <= sum_q;
					root_q <= '0;
					root_cnt_q <= RootCntBits'(1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						root_q <= (root_q >> 1) + bitv;
					end else begin
						root_q <= root_q >> 1;
					end
					root_cnt_q <= root_cnt_q + 1'b1;
					if (32'(root_cnt_q) == RootBits) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					result_valid <= 1'b1;
					result.earlier_id <= id_rdata;
					result.later_id <= later_id_q;
					result.distance <= (root_q > SumBits'({DistBits{1'b1}})) ? '1
						: DistBits'(root_q);
					result.status <= 1'b0;
					result.last_result <= 32'(pair_q) + 1 == 32'(stored_count_q);
					if (32'(pair_q) + 1 == 32'(stored_count_q)) begin
						stored_count_q <= stored_count_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						pair_q <= pair_q + 1'b1;
						rd_idx_q <= '0;
						cur_phase_q <= 2'd1;
						sum_q <= '0;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "pairwise_euclidean_distance_assert.svh"

	`PED_ASSERT_IMPL(a_result_idle_done, result_valid && result.last_result,
		state_q == ST_IDLE, "last result while still working")
	`PED_ASSERT_IMPL(a_count_bound, 1'b1,
		32'(stored_count_q) <= MAX_DESCRIPTORS, "stored count beyond store")
	`PED_ASSERT_NEXT(a_full_drop, accept && full && item.end_of_descriptor,
		result_valid && result.status, "dropped descriptor not flagged")
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the pairwise Euclidean distance block.
// Depends on ped_pkg and the pairwise_euclidean_distance RTL; needs no files.
// A scoreboard class predicts every distance and drop report from the accepted elements.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 5000;
	localparam int TailCycles = 300;
	localparam int TargetItems = 410;

	class distance_scoreboard;
		int signed vectors[ped_pkg::MaxDescriptors][ped_pkg::MaxDim];
		logic [15:0] ids[ped_pkg::MaxDescriptors];
		int stored;
		int elem_idx;
		logic [ped_pkg::DimCountBits-1:0] dim_reg;
		ped_pkg::out_item_t expected_q[$];
		int errors;

		function new();
			stored = 0;
			elem_idx = 0;
			dim_reg = ped_pkg::DimCountBits'(ped_pkg::DimCountReset);
			errors = 0;
		endfunction

		function int active_dim();
			if (dim_reg == 0) begin
				return 1;
			end
			if (dim_reg > ped_pkg::MaxDim) begin
				return ped_pkg::MaxDim;
			end
			return int'(dim_reg);
		endfunction

		function longint unsigned floor_sqrt(longint unsigned x);
			longint unsigned root;
			longint unsigned bitv;
			root = 0;
			bitv = 64'h1 << 62;
			while (bitv > x) begin
				bitv = bitv >> 2;
			end
			while (bitv != 0) begin
				if (x >= root + bitv) begin
					x = x - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		function void note_element(ped_pkg::in_item_t it);
			int d;
			bit full;
			longint unsigned sum;
			longint signed diff;
			ped_pkg::out_item_t r;
			d = active_dim();
			if (it.start_of_set) begin
				stored = 0;
				elem_idx = 0;
			end
			full = stored >= ped_pkg::MaxDescriptors;
			if (elem_idx < d) begin
				if (!full) begin
					vectors[stored][elem_idx] = int'(it.element_value);
				end
				elem_idx++;
			end
			if (!it.end_of_descriptor) begin
				return;
			end
			if (full) begin
				elem_idx = 0;
				r = '0;
				r.later_id = it.descriptor_id;
				r.status = 1'b1;
				r.last_result = 1'b1;
				expected_q.push_back(r);
				return;
			end
			for (int e = elem_idx; e < ped_pkg::MaxDim; e++) begin
				vectors[stored][e] = 0;
			end
			ids[stored] = it.descriptor_id;
			elem_idx = 0;
			for (int k = 0; k < stored; k++) begin
				sum = 0;
				for (int e = 0; e < d; e++) begin
					diff = longint'(vectors[k][e]) - longint'(vectors[stored][e]);
					sum += longint'(diff * diff);
				end
				r.earlier_id = ids[k];
				r.later_id = it.descriptor_id;
				r.distance = 20'(floor_sqrt(sum));
				r.status = 1'b0;
				r.last_result = (k + 1 == stored);
				expected_q.push_back(r);
			end
			stored++;
		endfunction

		function void check_result(ped_pkg::out_item_t got);
			ped_pkg::out_item_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: got %h %h %h %b %b", $time, got.earlier_id,
					got.later_id, got.distance, got.status, got.last_result);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got != exp_r) begin
				$display("%0t: mismatch: expected %h %h %h %b %b, actual %h %h %h %b %b", $time,
					exp_r.earlier_id, exp_r.later_id, exp_r.distance, exp_r.status,
					exp_r.last_result, got.earlier_id, got.later_id, got.distance, got.status,
					got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ped_pkg::in_item_t item;
	logic result_valid;
	ped_pkg::out_item_t result;
	logic dim_count_we;
	logic [ped_pkg::DimCountBits-1:0] dim_count_wdata;

	distance_scoreboard sb;
	int idle_pct;
	int items_sent;
	int quiet_cycles;

	pairwise_euclidean_distance u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.dim_count_we(dim_count_we),
		.dim_count_wdata(dim_count_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= StallLimit) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_element(input logic [15:0] id, input logic [15:0] val,
			input logic eod, input logic sos);
		ped_pkg::in_item_t it;
		it.descriptor_id = id;
		it.element_value = val;
		it.end_of_descriptor = eod;
		it.start_of_set = sos;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sb.note_element(it);
		items_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0 || busy) begin
			@(posedge clk);
		end
	endtask

	task automatic write_dim(input logic [ped_pkg::DimCountBits-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		dim_count_we <= 1'b1;
		dim_count_wdata <= value;
		@(posedge clk);
		dim_count_we <= 1'b0;
		sb.dim_reg = value;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// One set of a few descriptors, usually well formed, sometimes with stray flags.
	task automatic random_set(input int dim);
		int n_desc;
		int len;
		n_desc = $urandom_range(2, 5);
		for (int k = 0; k < n_desc; k++) begin
			len = dim + $urandom_range(0, 2) - 1;
			if (len < 1) begin
				len = 1;
			end
			for (int e = 0; e < len; e++) begin
				if ($urandom_range(19) == 0) begin
					send_element(16'($urandom), pick_value(), 1'($urandom), 1'($urandom));
				end else begin
					send_element(16'($urandom), pick_value(), e == len - 1,
						k == 0 && e == 0);
				end
			end
		end
	endtask

	initial begin
		int dims[5];
		int idles[4];
		int dim_now;
		sb = new();
		items_sent = 0;
		idle_pct = 0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		dim_count_we <= 1'b0;
		dim_count_wdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme values, missing and extra elements, restart mid-descriptor.
		write_dim(7'd3);
		send_element(16'hFFFF, 16'h7FFF, 1'b0, 1'b1);
		send_element(16'hFFFF, 16'h7FFF, 1'b0, 1'b0);
		send_element(16'hFFFF, 16'h7FFF, 1'b1, 1'b0);
		send_element(16'h0000, 16'h8000, 1'b0, 1'b0);
		send_element(16'h0000, 16'h8000, 1'b0, 1'b0);
		send_element(16'h0000, 16'h8000, 1'b1, 1'b0);
		send_element(16'h1234, 16'h0001, 1'b1, 1'b0);
		for (int e = 0; e < 5; e++) begin
			send_element(16'h5555, 16'hAAAA, e == 4, 1'b0);
		end
		send_element(16'h0F0F, 16'h0100, 1'b0, 1'b0);
		send_element(16'hF0F0, 16'hFF00, 1'b1, 1'b1);
		send_element(16'h0001, 16'hFFFF, 1'b1, 1'b0);

		// Extreme dim settings: zero acts as one, the top value acts as the maximum.
		write_dim(7'd0);
		send_element(16'h0002, 16'h7FFF, 1'b1, 1'b1);
		send_element(16'h0003, 16'h8000, 1'b1, 1'b0);
		write_dim(7'd127);
		for (int k = 0; k < 2; k++) begin
			for (int e = 0; e < 64; e++) begin
				send_element(16'($urandom), pick_value(), e == 63, k == 0 && e == 0);
			end
		end
		// A later, larger dim reads the zero-filled tail of short descriptors.
		write_dim(7'd2);
		send_element(16'h0010, 16'h0300, 1'b1, 1'b1);
		write_dim(7'd64);
		send_element(16'h0011, 16'hFD00, 1'b0, 1'b0);
		send_element(16'h0012, 16'h0001, 1'b1, 1'b0);

		// Fill the store past capacity so the last descriptors are dropped.
		write_dim(7'd1);
		for (int k = 0; k < ped_pkg::MaxDescriptors + 2; k++) begin
			send_element(16'($urandom), pick_value(), 1'b1, k == 0);
		end

		dims = '{1, 2, 4, 8, 64};
		idles = '{0, 82, 0, 18};
		for (int p = 0; items_sent < TargetItems; p++) begin
			dim_now = dims[p % 5];
			if (dim_now == 64 && p > 5) begin
				dim_now = $urandom_range(2, 6);
			end
			write_dim(7'(dim_now));
			idle_pct = idles[p % 4];
			for (int s = 0; s < 4 && items_sent < TargetItems; s++) begin
				random_set(dim_now);
				if (dim_now == 64) begin
					break;
				end
			end
			if (p == 1) begin
				drain();
			end
		end

		drain();
		repeat (TailCycles) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/ped_pkg.sv
src/ped_ram.sv
src/pairwise_euclidean_distance.sv
tb/testbench.sv
